### sv/ktq_pkg.sv
// shared types and constants for the keyed timer expiry queue
package ktq_pkg;

    localparam int CMD_W       = 2;
    localparam int SESSION_W   = 6;
    localparam int INTERVAL_W  = 32;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // command codes on the request port
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_SCHED,
        OP_CANCEL,
        OP_TICK,
        OP_ADVANCE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SESSION_W-1:0]  session;
        logic [INTERVAL_W-1:0] interval;
    } item_t;

    // head of the front queue as seen by the back
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_EVAL,
        BK_FLUSH
    } bk_state_t;

    // back status for observation at the top
    typedef struct packed {
        logic busy;
        logic pending;
    } bk_status_t;

endpackage

### sv/keyed_timer_expiry_queue_core.sv
// A request is registered into the front queue; schedule, cancel and a disabled tick
// are then handled by the back end in BK_IDLE, which it does not leave for them.
// An enabled tick runs one min scan pass (BK_SCAN, BK_DRAIN, BK_EVAL) per expiry, then
// either a pass that finds none or, at the 64-result cap, BK_FLUSH; each pass reads the
// target memory once per slot, and a held result can wait on out_ready.
// Throughput: one request per cycle into a two-entry queue while the back is free.
// Reset: time counter zero, all timers disarmed, enable set; target memory not cleared.
module keyed_timer_expiry_queue_core import ktq_pkg::*; #(
    parameter int SLOTS     = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [SESSION_W-1:0]  session,
    input  logic [INTERVAL_W-1:0] interval,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SESSION_W-1:0]  expired_session,
    output logic                  last
);

    logic       enable_reg;
    q_out_t     q_out;
    logic       pop;
    bk_status_t bk_status;

    // enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    ktq_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (enable_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .session  (session),
        .interval (interval),
        .pop      (pop),
        .q_out    (q_out)
    );

    ktq_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_out           (q_out),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .expired_session (expired_session),
        .last            (last),
        .bk_status       (bk_status)
    );

`ifndef SYNTHESIS
    // a held result exists only inside a tick
    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.pending |-> bk_status.busy)
        else $error("held result outside a tick");

    // a new result comes only from a tick in progress
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bk_status.busy))
        else $error("result raised while back end idle");

    // expired slots stay within the table
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SLOTS > 64) || (32'(expired_session) < 32'(SLOTS)))
        else $error("expired slot out of range");
`endif

endmodule

### sv/ktq_ram.sv
// generic single write port memory with registered read
module ktq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ktq_front.sv
// front end: takes requests, classifies them and queues them for the back
module ktq_front import ktq_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [SESSION_W-1:0]  session,
    input  logic [INTERVAL_W-1:0] interval,
    input  logic                  pop,
    output q_out_t                q_out
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       in_range;
    logic       push;
    item_t      item;

    // classify the request; meaningless ones are taken and dropped
    always_comb
    begin
        in_range      = 32'(session) < 32'(SLOTS);
        keep          = 1'b1;
        item.op       = OP_TICK;
        item.session  = session;
        item.interval = interval;
        case (command)
            CMD_SCHEDULE:
            begin
                item.op = OP_SCHED;
                keep    = enable && in_range;
            end
            CMD_CANCEL:
            begin
                item.op = OP_CANCEL;
                keep    = in_range;
            end
            CMD_TICK:
            begin
                item.op = enable ? OP_TICK : OP_ADVANCE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = q_reg[rd_ptr_reg];

endmodule

### sv/ktq_back.sv
// back end: timer table, time counter, expiry scan and result register
module ktq_back import ktq_pkg::*; #(
    parameter int SLOTS     = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_out_t               q_out,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SESSION_W-1:0] expired_session,
    output logic                 last,
    output bk_status_t           bk_status
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SUM_W  = ((TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W) + 1;

    bk_state_t            state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [SLOTS-1:0]     armed_reg, armed_next;
    logic [SLOT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic                 best_found_reg, best_found_next;
    logic [SLOT_W-1:0]    best_slot_reg, best_slot_next;
    logic [TIME_BITS-1:0] best_time_reg, best_time_next;
    logic                 pending_reg, pending_next;
    logic [SLOT_W-1:0]    pending_slot_reg, pending_slot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_last_reg;

    logic                 out_load;
    logic [SLOT_W-1:0]    out_slot_load;
    logic                 out_last_load;
    logic                 out_free;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [TIME_BITS-1:0] ram_wdata;
    logic [TIME_BITS-1:0] ram_rdata;
    logic [SUM_W-1:0]     sched_sum;
    logic [TIME_BITS-1:0] sched_target;
    logic [TIME_BITS-1:0] now_inc;
    logic                 cand;
    logic [SLOT_W-1:0]    item_slot;

    // target times
    ktq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_target_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // saturating target and time arithmetic
    always_comb
    begin
        sched_sum = SUM_W'(now_reg) + SUM_W'(q_out.item.interval);
        if (sched_sum[SUM_W-1:TIME_BITS] != '0)
        begin
            sched_target = '1;
        end
        else
        begin
            sched_target = sched_sum[TIME_BITS-1:0];
        end
        now_inc = (now_reg == '1) ? now_reg : now_reg + TIME_BITS'(1);
    end

    assign item_slot = SLOT_W'(q_out.item.session);
    assign out_free  = !out_valid_reg || out_ready;

    // expiry candidate from the slot read last cycle
    assign cand = rd_valid_reg && armed_reg[rd_slot_reg] && (ram_rdata <= now_reg);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        armed_next        = armed_reg;
        scan_addr_next    = scan_addr_reg;
        rd_valid_next     = 1'b0;
        best_found_next   = best_found_reg;
        best_slot_next    = best_slot_reg;
        best_time_next    = best_time_reg;
        pending_next      = pending_reg;
        pending_slot_next = pending_slot_reg;
        cnt_next          = cnt_reg;
        out_load          = 1'b0;
        out_slot_load     = pending_slot_reg;
        out_last_load     = 1'b0;
        pop               = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = item_slot;
        ram_wdata         = sched_target;

        // running minimum over target time, earlier slot wins a tie
        if (cand && (!best_found_reg || (ram_rdata < best_time_reg)))
        begin
            best_found_next = 1'b1;
            best_slot_next  = rd_slot_reg;
            best_time_next  = ram_rdata;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (q_out.valid)
                begin
                    pop = 1'b1;
                    case (q_out.item.op)
                        OP_SCHED:
                        begin
                            ram_we                = 1'b1;
                            armed_next[item_slot] = 1'b1;
                        end
                        OP_CANCEL:
                        begin
                            armed_next[item_slot] = 1'b0;
                        end
                        OP_TICK:
                        begin
                            now_next        = now_inc;
                            scan_addr_next  = '0;
                            best_found_next = 1'b0;
                            cnt_next        = '0;
                            pending_next    = 1'b0;
                            state_next      = BK_SCAN;
                        end
                        default:
                        begin
                            now_next = now_inc;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                rd_valid_next = 1'b1;
                if (scan_addr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = BK_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + SLOT_W'(1);
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_EVAL;
            end
            BK_EVAL:
            begin
                if (!pending_reg || out_free)
                begin
                    // release the held result now that we know if more follow
                    if (pending_reg)
                    begin
                        out_load      = 1'b1;
                        out_last_load = !best_found_reg;
                    end
                    if (best_found_reg)
                    begin
                        armed_next[best_slot_reg] = 1'b0;
                        pending_next              = 1'b1;
                        pending_slot_next         = best_slot_reg;
                        cnt_next                  = cnt_reg + CNT_W'(1);
                        if (cnt_reg == CNT_W'(MAX_RESULTS - 1))
                        begin
                            state_next = BK_FLUSH;
                        end
                        else
                        begin
                            scan_addr_next  = '0;
                            best_found_next = 1'b0;
                            state_next      = BK_SCAN;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        state_next   = BK_IDLE;
                    end
                end
            end
            BK_FLUSH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_load = 1'b1;
                    pending_next  = 1'b0;
                    state_next    = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            now_reg        <= '0;
            armed_reg      <= '0;
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            pending_reg    <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            scan_addr_reg  <= scan_addr_next;
            rd_valid_reg   <= rd_valid_next;
            best_found_reg <= best_found_next;
            pending_reg    <= pending_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg      <= scan_addr_reg;
        best_slot_reg    <= best_slot_next;
        best_time_reg    <= best_time_next;
        pending_slot_reg <= pending_slot_next;
        if (out_load)
        begin
            out_slot_reg <= out_slot_load;
            out_last_reg <= out_last_load;
        end
    end

    assign out_valid         = out_valid_reg;
    assign expired_session   = SESSION_W'(out_slot_reg);
    assign last              = out_last_reg;
    assign bk_status.busy    = (state_reg != BK_IDLE);
    assign bk_status.pending = pending_reg;

endmodule

### dv/testbench.sv
// self-checking testbench for the keyed timer expiry queue core
module testbench import ktq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS     = 64;
    localparam int TIME_W        = 48;
    localparam int TOTAL_ITEMS   = 385;
    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int N_ROWS        = 25;

    // command code with no defined action
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one expiry as it should leave the block
    typedef struct packed {
        logic [SESSION_W-1:0] sess;
        logic                 last_f;
    } expiry_t;

    // directed stimulus row, with a typed-in expectation where marked
    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [SESSION_W-1:0]       sess;
        logic [INTERVAL_W-1:0]      iv;
        logic                       wr_cfg;
        logic                       cfg_val;
        logic                       typed;
        logic [1:0]                 n_exp;
        logic [0:2][SESSION_W-1:0]  ex;
    } step_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = CMD_TICK;
    logic [SESSION_W-1:0]  session = '0;
    logic [INTERVAL_W-1:0] interval = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SESSION_W-1:0]  expired_session;
    logic                  last;

    // timer table mirror
    logic [TIME_W-1:0] clock_now;
    logic              slot_armed [NUM_SLOTS];
    logic [TIME_W-1:0] deadline [NUM_SLOTS];
    logic              run_en;

    expiry_t due_now [$];
    expiry_t expiry_q [$];

    int errors = 0;
    int live_items = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // directed part: extremes, every command, tie order, disable behavior
    step_row_t rows [N_ROWS] = '{
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd0,  32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd63, 32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd2, '{6'd0, 6'd63, 6'd0}},
        '{CMD_SCHEDULE, 6'd5,  32'd3,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd9,  32'd1,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd9,  32'd2,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_CANCEL,   6'd5,  32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_CANCEL,   6'd5,  32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_UNUSED,   6'd5,  32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd63, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd1, '{6'd9, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd1,  32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd2,  32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd40, 32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd7,  32'd1,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd3, '{6'd2, 6'd40, 6'd7}},
        '{CMD_CANCEL,   6'd1,  32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd12, 32'd1,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd13, 32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_SCHEDULE, 6'd10, 32'd0,          1'b1, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_CANCEL,   6'd13, 32'd0,          1'b0, 1'b0, 1'b0, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd0, '{6'd0, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b1, 1'b1, 1'b1, 2'd1, '{6'd12, 6'd0, 6'd0}},
        '{CMD_TICK,     6'd0,  32'd0,          1'b0, 1'b0, 1'b1, 2'd0, '{6'd0, 6'd0, 6'd0}}
    };

    keyed_timer_expiry_queue_core #(
        .SLOTS     (NUM_SLOTS),
        .TIME_BITS (TIME_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .session         (session),
        .interval        (interval),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .expired_session (expired_session),
        .last            (last)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // saturating add at the time width
    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // update the timer table for one request and collect the expiries it causes
    function automatic void compute_expiries(input logic [CMD_W-1:0] cmd,
                                             input logic [SESSION_W-1:0] sess,
                                             input logic [INTERVAL_W-1:0] iv);
        int      pick;
        expiry_t e;
        due_now.delete();
        case (cmd)
            CMD_SCHEDULE:
            begin
                if (run_en)
                begin
                    deadline[sess]   = sat_time(clock_now, {{(TIME_W-INTERVAL_W){1'b0}}, iv});
                    slot_armed[sess] = 1'b1;
                end
            end
            CMD_CANCEL:
                slot_armed[sess] = 1'b0;
            CMD_TICK:
            begin
                clock_now = sat_time(clock_now, {{(TIME_W-1){1'b0}}, 1'b1});
                if (run_en)
                begin
                    // earliest deadline first, lower slot wins a tie
                    while (due_now.size() < MAX_RESULTS)
                    begin
                        pick = -1;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (slot_armed[i] && deadline[i] <= clock_now)
                            begin
                                if (pick < 0 || deadline[i] < deadline[pick])
                                    pick = i;
                            end
                        end
                        if (pick < 0)
                            break;
                        slot_armed[pick] = 1'b0;
                        e.sess   = pick[SESSION_W-1:0];
                        e.last_f = 1'b0;
                        due_now.push_back(e);
                    end
                    if (due_now.size() > 0)
                        due_now[due_now.size()-1].last_f = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // random interval, mostly short so that timers expire within a few ticks
    function automatic logic [INTERVAL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 85)
            return $urandom_range(7, 40);
        else if (r < 92)
            return $urandom();
        else if (r < 96)
            return 32'hFFFF_FFFF;
        return '0;
    endfunction

    // send one request in bursts with random gaps, called at a falling edge
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SESSION_W-1:0] sess,
                         input logic [INTERVAL_W-1:0] iv, input logic typed,
                         input logic [1:0] n_exp, input logic [0:2][SESSION_W-1:0] ex);
        int      gap;
        int      r;
        expiry_t e;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            r = $urandom_range(0, 9);
            if (r < 6)
                gap = $urandom_range(1, 4);
            else if (r < 9)
                gap = $urandom_range(5, 12);
            else
                gap = $urandom_range(20, 40);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid = 1'b1;
        command  = cmd;
        session  = sess;
        interval = iv;
        do @(posedge clk); while (!in_ready);
        live_items++;
        compute_expiries(cmd, sess, iv);
        if (typed)
        begin
            for (int i = 0; i < n_exp; i++)
            begin
                e.sess   = ex[i];
                e.last_f = (i == n_exp - 1);
                expiry_q.push_back(e);
            end
        end
        else
        begin
            foreach (due_now[i])
                expiry_q.push_back(due_now[i]);
        end
        burst_left--;
        @(negedge clk);
    endtask

    // hold the sender until every expiry is out and the back end has settled
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (expiry_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // write the enable register, block idle
    task automatic write_enable(input logic v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(posedge clk);
        run_en = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // receiver stall pattern: free-running, coin flips, periodic, long stalls
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 150);
        end
        stall_left--;
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
            0:       out_ready = 1'b1;
            1:       out_ready = 1'($urandom_range(0, 1));
            2:       out_ready = (stall_phase >= 3);
            default: out_ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    // expiry checker
    always @(posedge clk)
    begin
        expiry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expiry_q.size() == 0)
            begin
                $error("unexpected expiry: session %0d last %0b", expired_session, last);
                errors++;
            end
            else
            begin
                want = expiry_q.pop_front();
                if (expired_session !== want.sess)
                begin
                    $error("expired_session: expected %0d, got %0d", want.sess,
                           expired_session);
                    errors++;
                end
                if (last !== want.last_f)
                begin
                    $error("last: expected %0b, got %0b", want.last_f, last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no expiry moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("timeout after %0d idle cycles, %0d expiries outstanding",
                     idle_cycles, expiry_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int   r;
        int   n;
        int   off;
        logic [SESSION_W-1:0] s;
        logic first_phase;

        clock_now = '0;
        run_en    = 1'b1;
        foreach (slot_armed[i])
        begin
            slot_armed[i] = 1'b0;
            deadline[i]   = '0;
        end
        first_phase = 1'b1;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (rows[i])
        begin
            if (rows[i].wr_cfg)
            begin
                wait_quiet();
                write_enable(rows[i].cfg_val);
            end
            issue(rows[i].cmd, rows[i].sess, rows[i].iv, rows[i].typed,
                  rows[i].n_exp, rows[i].ex);
        end
        wait_quiet();

        // random phases, each ending with the block drained and idle
        while (live_items < TOTAL_ITEMS)
        begin
            if (first_phase || $urandom_range(0, 9) == 0)
            begin
                // schedule every slot (armed only while enabled), then tick through the expiries
                off = $urandom_range(0, NUM_SLOTS - 1);
                r = first_phase ? 0 : $urandom_range(0, 3);
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    s = SESSION_W'((k + off) % NUM_SLOTS);
                    issue(CMD_SCHEDULE, s, r, 1'b0, 2'd0, '0);
                end
                repeat (4)
                    issue(CMD_TICK, SESSION_W'($urandom()), $urandom(), 1'b0, 2'd0, '0);
                first_phase = 1'b0;
            end
            else
            begin
                n = $urandom_range(15, 45);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        issue(CMD_SCHEDULE, SESSION_W'($urandom()), pick_interval(),
                              1'b0, 2'd0, '0);
                    else if (r < 55)
                        issue(CMD_CANCEL, SESSION_W'($urandom()), $urandom(),
                              1'b0, 2'd0, '0);
                    else if (r < 94)
                        issue(CMD_TICK, SESSION_W'($urandom()), $urandom(),
                              1'b0, 2'd0, '0);
                    else
                        issue(CMD_UNUSED, SESSION_W'($urandom()), $urandom(),
                              1'b0, 2'd0, '0);
                end
            end
            wait_quiet();
            write_enable($urandom_range(0, 3) != 0);
        end
        wait_quiet();

        if (expiry_q.size() != 0)
        begin
            $error("%0d expiries never arrived", expiry_q.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
